[rtl/sidld_pkg.sv]
// Shared types, constants and the reference level table for the slot ID
// level detector. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sidld_pkg;

    localparam int LEVEL_COUNT_DEFAULT = 10;
    localparam int GROUP_SIZE_DEFAULT  = 4;
    localparam int LEVEL_TABLE_DEPTH   = 10;

    localparam int SAMPLE_W = 12;
    localparam int CODE_W   = 4;

    localparam logic [SAMPLE_W-1:0] WINDOW_RESET = 12'd128;
    localparam logic [CODE_W-1:0]   CODE_NONE    = 4'd0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered_value;
        logic [CODE_W-1:0]   level_code;
    } sidld_result_t;

    // Reference level of a 0-based level index; levels past the table read 0.
    function automatic logic [SAMPLE_W-1:0] level_ref(input logic [CODE_W-1:0] idx);
        logic [SAMPLE_W-1:0] ref_value;
        case (idx)
            4'd0:    ref_value = 12'h0F7;
            4'd1:    ref_value = 12'h1EF;
            4'd2:    ref_value = 12'h2E7;
            4'd3:    ref_value = 12'h3DF;
            4'd4:    ref_value = 12'h4D8;
            4'd5:    ref_value = 12'h5D0;
            4'd6:    ref_value = 12'h6C8;
            4'd7:    ref_value = 12'h7C0;
            4'd8:    ref_value = 12'h8B9;
            4'd9:    ref_value = 12'h9B1;
            default: ref_value = '0;
        endcase
        return ref_value;
    endfunction

endpackage

`default_nettype wire

[rtl/slot_id_level_detector.sv]
// Slot ID level detector top level: input register, classify logic, group
// tracking and result register. Depends on sidld_pkg and sidld_classify.
// The input register feeds the result register, which drives m_tdata/m_tuser.
// Throughput: one sample set per cycle while m_tready takes results; while a
// result waits the input register takes one more transaction, then s_tready drops.
// Reset (aresetn low, synchronous): pipeline empty, groups cleared, window 128.
`timescale 1ns / 1ps
`default_nettype none

module slot_id_level_detector #(
    parameter int LEVEL_COUNT = sidld_pkg::LEVEL_COUNT_DEFAULT,
    parameter int GROUP_SIZE  = sidld_pkg::GROUP_SIZE_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data,    // window_half_width

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,     // sample_a, sample_b, sample_c, sample_d

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // filtered_value, level_code, slot_id, zero pad
    output logic             m_tuser      // id_valid
);

    localparam int SW    = sidld_pkg::SAMPLE_W;
    localparam int CW    = sidld_pkg::CODE_W;
    localparam int POS_W = $clog2(GROUP_SIZE);

    logic [SW-1:0]     window_reg;
    logic [4*SW-1:0]   in_data_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [SW-1:0]     out_value_reg;
    logic [CW-1:0]     out_code_reg;
    logic              out_locked_reg;
    logic [CW-1:0]     out_slot_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CW-1:0]     first_reg, first_next;
    logic              all_eq_reg, all_eq_next;
    logic              locked_reg, locked_next;
    logic [CW-1:0]     slot_reg, slot_next;

    logic              s_accept, advance, out_free;
    sidld_pkg::sidld_result_t cls;

    assign cfg_ready = 1'b1;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    sidld_classify #(
        .LEVEL_COUNT(LEVEL_COUNT)
    ) u_classify (
        .sample_a          (in_data_reg[SW-1:0]),
        .sample_b          (in_data_reg[2*SW-1:SW]),
        .sample_c          (in_data_reg[3*SW-1:2*SW]),
        .sample_d          (in_data_reg[4*SW-1:3*SW]),
        .window_half_width (window_reg),
        .result            (cls)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // group tracking, frozen once locked
    always_comb begin
        pos_next    = pos_reg;
        first_next  = first_reg;
        all_eq_next = all_eq_reg;
        locked_next = locked_reg;
        slot_next   = slot_reg;
        if (advance && !locked_reg) begin
            if (pos_reg == '0) begin
                first_next  = cls.level_code;
                all_eq_next = 1'b1;
            end else if (cls.level_code != first_reg) begin
                all_eq_next = 1'b0;
            end
            if (pos_reg == POS_W'(GROUP_SIZE - 1)) begin
                pos_next = '0;
                if (all_eq_next && first_next != sidld_pkg::CODE_NONE) begin
                    locked_next = 1'b1;
                    slot_next   = first_next;
                end
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= sidld_pkg::WINDOW_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            first_reg     <= sidld_pkg::CODE_NONE;
            all_eq_reg    <= 1'b1;
            locked_reg    <= 1'b0;
            slot_reg      <= sidld_pkg::CODE_NONE;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            all_eq_reg    <= all_eq_next;
            locked_reg    <= locked_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_value_reg  <= cls.filtered_value;
            out_code_reg   <= cls.level_code;
            out_locked_reg <= locked_next;
            out_slot_reg   <= slot_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_slot_reg, out_code_reg, out_value_reg};
    assign m_tuser  = out_locked_reg;

endmodule

`default_nettype wire

[rtl/sidld_classify.sv]
// Median-of-four filter and windowed level match for one sample set.
// Depends on sidld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sidld_classify #(
    parameter int LEVEL_COUNT = sidld_pkg::LEVEL_COUNT_DEFAULT
) (
    input  wire logic [sidld_pkg::SAMPLE_W-1:0] sample_a,
    input  wire logic [sidld_pkg::SAMPLE_W-1:0] sample_b,
    input  wire logic [sidld_pkg::SAMPLE_W-1:0] sample_c,
    input  wire logic [sidld_pkg::SAMPLE_W-1:0] sample_d,
    input  wire logic [sidld_pkg::SAMPLE_W-1:0] window_half_width,
    output sidld_pkg::sidld_result_t            result
);

    localparam int SW = sidld_pkg::SAMPLE_W;
    localparam int CW = sidld_pkg::CODE_W;

    logic [SW-1:0]      max_ab, max_cd, min_ab, min_cd, hi, lo;
    logic [SW+1:0]      sum_all;
    logic [SW+1:0]      mid_sum;
    logic [SW-1:0]      filtered;
    logic [LEVEL_COUNT-1:0] hit;
    logic [CW-1:0]      code;

    // drop one largest and one smallest, halve the rest
    always_comb begin
        max_ab  = (sample_a > sample_b) ? sample_a : sample_b;
        min_ab  = (sample_a > sample_b) ? sample_b : sample_a;
        max_cd  = (sample_c > sample_d) ? sample_c : sample_d;
        min_cd  = (sample_c > sample_d) ? sample_d : sample_c;
        hi      = (max_ab > max_cd) ? max_ab : max_cd;
        lo      = (min_ab < min_cd) ? min_ab : min_cd;
        sum_all = {2'b00, sample_a} + {2'b00, sample_b}
                + {2'b00, sample_c} + {2'b00, sample_d};
        mid_sum = sum_all - {2'b00, hi} - {2'b00, lo};
        filtered = mid_sum[SW:1];
    end

    always_comb begin
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            logic [SW-1:0] ref_value;
            logic [SW:0]   upper;
            logic [SW-1:0] lower;
            ref_value = sidld_pkg::level_ref(CW'(i));
            upper     = {1'b0, ref_value} + {1'b0, window_half_width};
            lower     = (ref_value > window_half_width) ? ref_value - window_half_width : '0;
            hit[i]    = ({1'b0, filtered} <= upper) && (filtered >= lower);
        end
    end

    // first matching level wins
    always_comb begin
        code = sidld_pkg::CODE_NONE;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                code = CW'(i + 1);
            end
        end
    end

    assign result.filtered_value = filtered;
    assign result.level_code     = code;

endmodule

`default_nettype wire

[rtl/sidld_checker.sv]
// Port-level checks for the slot ID level detector, bound to the top level.
// Depends on sidld_pkg and slot_id_level_detector.
`timescale 1ns / 1ps
`default_nettype none

module sidld_checker #(
    parameter int LEVEL_COUNT = sidld_pkg::LEVEL_COUNT_DEFAULT
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser
);

    logic       seen_lock_reg;
    logic [3:0] seen_slot_reg;
    logic       m_accept;

    assign m_accept = m_tvalid && m_tready;

    // track the first locked slot ID delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_lock_reg <= 1'b0;
            seen_slot_reg <= '0;
        end else if (m_accept && m_tuser && !seen_lock_reg) begin
            seen_lock_reg <= 1'b1;
            seen_slot_reg <= m_tdata[19:16];
        end
    end

    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && seen_lock_reg |-> m_tuser && m_tdata[19:16] == seen_slot_reg)
        else $error("slot ID lock changed after latching");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[19:16] == 4'd0)
        else $error("slot ID nonzero before lock");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:12] <= 4'(LEVEL_COUNT) && m_tdata[23:20] == 4'd0)
        else $error("level code out of range or pad bits set");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

endmodule

bind slot_id_level_detector sidld_checker #(
    .LEVEL_COUNT(LEVEL_COUNT)
) u_sidld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[sim/tb.sv]
// Self-checking bench for slot_id_level_detector: directed table, then randomized
// phases over several window widths, with randomized stalls on both streams.
// Depends on sidld_pkg and the slot_id_level_detector RTL.
`timescale 1ns / 1ps

module tb;

    localparam int LEVELS       = sidld_pkg::LEVEL_COUNT_DEFAULT;
    localparam int GROUP        = sidld_pkg::GROUP_SIZE_DEFAULT;
    localparam int NO_CFG       = -1;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 300;
    localparam int RUN_LIMIT    = 600000;

    localparam logic [11:0] REF_LEVEL [0:9] = '{
        12'h0F7, 12'h1EF, 12'h2E7, 12'h3DF, 12'h4D8,
        12'h5D0, 12'h6C8, 12'h7C0, 12'h8B9, 12'h9B1
    };

    typedef struct packed {
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] c;
        logic [11:0] d;
    } reading_t;

    typedef struct packed {
        logic [11:0] filtered_value;
        logic [3:0]  level_code;
        logic        id_valid;
        logic [3:0]  slot_id;
    } slot_report_t;

    typedef struct {
        int           cfg;
        reading_t     r;
        bit           typed;
        slot_report_t want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;     // sample_a, sample_b, sample_c, sample_d
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // filtered_value, level_code, slot_id, zero pad
    logic        m_tuser;     // id_valid

    logic [11:0] pred_window = sidld_pkg::WINDOW_RESET;
    int          grp_pos     = 0;
    logic [3:0]  grp_first   = sidld_pkg::CODE_NONE;
    bit          grp_same    = 1'b1;
    bit          id_locked   = 1'b0;
    logic [3:0]  id_code     = sidld_pkg::CODE_NONE;

    slot_report_t pending_reports [$];
    slot_report_t oldest_report;
    plan_row_t    directed_plan [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           hold_off_req   = 1'b0;

    slot_id_level_detector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic logic [11:0] middle_mean(input reading_t r);
        logic [11:0] s [4];
        logic [11:0] hi;
        logic [11:0] lo;
        logic [13:0] total;
        s[0] = r.a;
        s[1] = r.b;
        s[2] = r.c;
        s[3] = r.d;
        hi = s[0];
        lo = s[0];
        total = '0;
        for (int i = 0; i < 4; i++) begin
            if (s[i] > hi) hi = s[i];
            if (s[i] < lo) lo = s[i];
            total += 14'(s[i]);
        end
        total = total - 14'(hi) - 14'(lo);
        return total[12:1];
    endfunction

    function automatic logic [3:0] level_of(input logic [11:0] v, input logic [11:0] w);
        logic [12:0] lvl_ref;
        logic [12:0] upper;
        logic [12:0] lower;
        for (int i = 0; i < LEVELS; i++) begin
            lvl_ref = (i < 10) ? 13'(REF_LEVEL[i]) : 13'd0;
            upper = lvl_ref + 13'(w);
            lower = (lvl_ref > 13'(w)) ? lvl_ref - 13'(w) : 13'd0;
            if (13'(v) <= upper && 13'(v) >= lower) return 4'(i + 1);
        end
        return sidld_pkg::CODE_NONE;
    endfunction

    task automatic predict_slot_report(input reading_t r, output slot_report_t rep);
        logic [3:0] code;
        rep.filtered_value = middle_mean(r);
        code = level_of(rep.filtered_value, pred_window);
        if (!id_locked) begin
            if (grp_pos == 0) begin
                grp_first = code;
                grp_same = 1'b1;
            end else if (code != grp_first) begin
                grp_same = 1'b0;
            end
            grp_pos++;
            if (grp_pos >= GROUP) begin
                grp_pos = 0;
                if (grp_same && grp_first != sidld_pkg::CODE_NONE) begin
                    id_locked = 1'b1;
                    id_code = grp_first;
                end
            end
        end
        rep.level_code = code;
        rep.id_valid = id_locked;
        rep.slot_id = id_code;
    endtask

    function automatic bit closes_matching_group(input reading_t r);
        return !id_locked && grp_pos == GROUP - 1 && grp_same
            && grp_first != sidld_pkg::CODE_NONE
            && level_of(middle_mean(r), pred_window) == grp_first;
    endfunction

    function automatic logic [11:0] to_sample(input int x);
        if (x < 0) return 12'd0;
        if (x > 4095) return 12'hFFF;
        return x[11:0];
    endfunction

    function automatic logic [11:0] extreme_sample();
        case ($urandom_range(0, 2))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic reading_t near_level_reading(input int lvl);
        int       spread;
        int       ctr;
        reading_t r;
        spread = ((pred_window > 12'd200) ? 200 : int'(pred_window)) + 4;
        ctr = int'(REF_LEVEL[lvl]) + int'($urandom_range(0, 2 * spread)) - spread;
        r.a = to_sample(ctr + int'($urandom_range(0, 6)) - 3);
        r.b = to_sample(ctr + int'($urandom_range(0, 6)) - 3);
        r.c = to_sample(ctr + int'($urandom_range(0, 6)) - 3);
        r.d = to_sample(ctr + int'($urandom_range(0, 6)) - 3);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: r.a = 12'($urandom_range(0, 4095));
                1: r.b = 12'($urandom_range(0, 4095));
                2: r.c = 12'($urandom_range(0, 4095));
                default: r.d = 12'($urandom_range(0, 4095));
            endcase
        end
        return r;
    endfunction

    function automatic reading_t noise_reading();
        reading_t r;
        case ($urandom_range(0, 2))
            0: begin
                r.a = 12'($urandom_range(0, 4095));
                r.b = 12'($urandom_range(0, 4095));
                r.c = 12'($urandom_range(0, 4095));
                r.d = 12'($urandom_range(0, 4095));
            end
            1: begin
                r.a = extreme_sample();
                r.b = extreme_sample();
                r.c = extreme_sample();
                r.d = extreme_sample();
            end
            default: begin
                r.a = 12'($urandom_range(0, 4095));
                r.b = r.a;
                r.c = r.a;
                r.d = r.a;
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic plan_row_t plan_row(input int cfg, input int a, input int b,
                                           input int c, input int d, input bit typed,
                                           input int fv, input int code);
        plan_row_t row;
        row.cfg = cfg;
        row.r.a = 12'(a);
        row.r.b = 12'(b);
        row.r.c = 12'(c);
        row.r.d = 12'(d);
        row.typed = typed;
        row.want.filtered_value = 12'(fv);
        row.want.level_code = 4'(code);
        row.want.id_valid = 1'b0;
        row.want.slot_id = sidld_pkg::CODE_NONE;
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input logic [11:0] got,
                                 input logic [11:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_reading(input reading_t r, input bit typed, input slot_report_t want);
        slot_report_t rep;
        int           gap;
        s_tvalid <= 1'b1;
        s_tdata <= {r.d, r.c, r.b, r.a};
        do @(posedge aclk); while (!s_tready);
        predict_slot_report(r, rep);
        pending_reports.push_back(typed ? want : rep);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic set_window(input logic [11:0] w);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pred_window = w;
    endtask

    task automatic run_phase(input int count, input bit allow_lock);
        reading_t     r;
        slot_report_t no_report;
        int           group_level;
        int           tries;
        no_report = '0;
        group_level = 0;
        for (int n = 0; n < count; n++) begin
            if (grp_pos == 0) group_level = $urandom_range(0, 9);
            if ($urandom_range(0, 99) < (allow_lock ? 85 : 60))
                r = near_level_reading(group_level);
            else
                r = noise_reading();
            tries = 0;
            // keep the slot unlatched until the lock phase
            while (!allow_lock && tries < 100 && closes_matching_group(r)) begin
                r = noise_reading();
                tries++;
            end
            send_reading(r, 1'b0, no_report);
        end
    endtask

    // receiver: random ready pattern, plus one long hold on request
    initial begin
        int run;
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("result without expectation", m_tdata[11:0], 12'd0);
            end else begin
                oldest_report = pending_reports.pop_front();
                if (m_tdata[11:0] !== oldest_report.filtered_value)
                    flag_mismatch("filtered_value", m_tdata[11:0],
                                  oldest_report.filtered_value);
                if (m_tdata[15:12] !== oldest_report.level_code)
                    flag_mismatch("level_code", 12'(m_tdata[15:12]),
                                  12'(oldest_report.level_code));
                if (m_tdata[19:16] !== oldest_report.slot_id)
                    flag_mismatch("slot_id", 12'(m_tdata[19:16]), 12'(oldest_report.slot_id));
                if (m_tuser !== oldest_report.id_valid)
                    flag_mismatch("id_valid", 12'(m_tuser), 12'(oldest_report.id_valid));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;

        directed_plan.push_back(plan_row(NO_CFG, 0, 0, 0, 0, 1'b1, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 4095, 4095, 4095, 4095, 1'b1, 4095, 0));
        directed_plan.push_back(plan_row(NO_CFG, 0, 4095, 0, 4095, 1'b1, 2047, 8));
        directed_plan.push_back(plan_row(NO_CFG, 247, 247, 247, 247, 1'b1, 247, 1));
        // window edges of level 1, overlap with level 2
        directed_plan.push_back(plan_row(NO_CFG, 118, 118, 118, 118, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 119, 119, 119, 119, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 370, 370, 370, 370, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 376, 376, 376, 376, 1'b0, 0, 0));
        // shared extremes, truncation, outliers
        directed_plan.push_back(plan_row(NO_CFG, 100, 100, 500, 500, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 7, 7, 7, 9, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 0, 1, 2, 3, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 4095, 1000, 1002, 0, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(0, 247, 247, 247, 247, 1'b1, 247, 1));
        directed_plan.push_back(plan_row(NO_CFG, 248, 248, 248, 248, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 2481, 2481, 2481, 2481, 1'b1, 2481, 10));
        directed_plan.push_back(plan_row(NO_CFG, 0, 0, 0, 0, 1'b0, 0, 0));
        // lower bound of level 1 clamped to zero
        directed_plan.push_back(plan_row(300, 0, 0, 0, 0, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 547, 547, 547, 547, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 548, 548, 548, 548, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 4095, 4095, 4095, 4095, 1'b1, 4095, 0));
        directed_plan.push_back(plan_row(4095, 4095, 4095, 4095, 4095, 1'b1, 4095, 1));
        directed_plan.push_back(plan_row(1, 248, 248, 248, 248, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 494, 494, 494, 494, 1'b0, 0, 0));
        directed_plan.push_back(plan_row(NO_CFG, 0, 0, 0, 0, 1'b0, 0, 0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].cfg != NO_CFG) set_window(12'(directed_plan[i].cfg));
            send_reading(directed_plan[i].r, directed_plan[i].typed, directed_plan[i].want);
        end

        set_window(12'd0);
        run_phase(220, 1'b0);
        set_window(12'd1);
        run_phase(220, 1'b0);
        set_window(12'd60);
        hold_off_req = 1'b1;
        run_phase(220, 1'b0);
        set_window(12'd300);
        run_phase(220, 1'b0);
        set_window(12'd1000);
        run_phase(220, 1'b0);
        set_window(12'($urandom_range(0, 2000)));
        run_phase(220, 1'b0);
        set_window(sidld_pkg::WINDOW_RESET);
        run_phase(200, 1'b1);
        set_window(12'hFFF);
        run_phase(120, 1'b1);
        set_window(12'($urandom_range(0, 4095)));
        run_phase(100, 1'b1);

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES * 4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
